>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the YCbCr to RGB converter.
// No dependencies; define ASSERT_OFF to compile the assertions away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Plain clocked property, given as a whole expression or implication
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/y2r_pkg.sv
// Shared constants and types for the YCbCr to RGB converter.
// No dependencies; used by the channel interfaces and the top level.
package y2r_pkg;

   // Sample and channel widths
   localparam int PIX_W = 8;

   // Default number of fractional coefficient bits
   localparam int COEF_FRAC_BITS_DEF = 14;

   // Control register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIDEO_RANGE = 1'b0,
      CSR_USE_BT709   = 1'b1
   } csr_index_type;

   // Matrix coefficients in millionths
   localparam longint unsigned COEF_DEN      = 64'd1000000;
   localparam longint unsigned BT709_RCR     = 64'd1574800;
   localparam longint unsigned BT709_GCB     = 64'd187324;
   localparam longint unsigned BT709_GCR     = 64'd468124;
   localparam longint unsigned BT709_BCB     = 64'd1855600;
   localparam longint unsigned BT601_RCR     = 64'd1402000;
   localparam longint unsigned BT601_GCB     = 64'd344136;
   localparam longint unsigned BT601_GCR     = 64'd714136;
   localparam longint unsigned BT601_BCB     = 64'd1772000;

   // Video range gains and offsets
   localparam longint unsigned VR_LUMA_NUM   = 64'd255;
   localparam longint unsigned VR_LUMA_DEN   = 64'd219;
   localparam longint unsigned VR_CHROMA_NUM = 64'd255;
   localparam longint unsigned VR_CHROMA_DEN = 64'd224;
   localparam int              LUMA_OFFSET   = 16;
   localparam int              CHROMA_OFFSET = 128;

endpackage

>>> hdl/y2r_if.sv
// Valid/ready channel interfaces for the YCbCr to RGB converter.
// Depends on y2r_pkg for the sample width.

// Input pixel channel: luma and chroma pair
interface y2r_req_if;
   import y2r_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] luma_sample;
   logic [PIX_W-1:0] cb_sample;
   logic [PIX_W-1:0] cr_sample;

   modport source (output valid, luma_sample, cb_sample, cr_sample, input ready);
   modport sink   (input valid, luma_sample, cb_sample, cr_sample, output ready);
endinterface

// Output pixel channel: RGB
interface y2r_rsp_if;
   import y2r_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> hdl/ycbcr_to_rgb_converter_unit.sv
// YCbCr to RGB converter, BT.601/BT.709, full or video range.
// Throughput: one pixel per clock unless rsp_chan.ready stalls the output;
// four register stages (offset, multiply, sum, clamp/round) each hold one
// transaction; a stage moves when empty or when the next one moves.
// Synchronous active-high reset clears all stage valids and both registers.
// Depends on y2r_pkg, y2r_if.sv and assert_macros.svh.
`include "assert_macros.svh"

module ycbcr_to_rgb_converter_unit #(
   parameter int COEF_FRAC_BITS = y2r_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [y2r_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [y2r_pkg::CSR_DATA_W-1:0] csr_wdata,
   y2r_req_if.sink                        req_chan,
   y2r_rsp_if.source                      rsp_chan
);
   import y2r_pkg::*;

   localparam int F  = COEF_FRAC_BITS;
   localparam int CW = F + 3;          // signed coefficient width
   localparam int DW = PIX_W + 1;      // signed offset sample width
   localparam int PW = DW + CW;        // product width
   localparam int SW = PW + 2;         // channel sum width

   // Fixed-point coefficients, rounded half up, range gain folded in
   localparam longint unsigned ONE = 64'd1;
   localparam longint unsigned D1  = COEF_DEN;
   localparam longint unsigned DV  = COEF_DEN * VR_CHROMA_DEN;

   localparam longint unsigned KL_V =
      ((VR_LUMA_NUM << (F + 1)) + VR_LUMA_DEN) / (2 * VR_LUMA_DEN);

   localparam longint unsigned K709_RCR_F = ((BT709_RCR << (F + 1)) + D1) / (2 * D1);
   localparam longint unsigned K709_GCB_F = ((BT709_GCB << (F + 1)) + D1) / (2 * D1);
   localparam longint unsigned K709_GCR_F = ((BT709_GCR << (F + 1)) + D1) / (2 * D1);
   localparam longint unsigned K709_BCB_F = ((BT709_BCB << (F + 1)) + D1) / (2 * D1);
   localparam longint unsigned K601_RCR_F = ((BT601_RCR << (F + 1)) + D1) / (2 * D1);
   localparam longint unsigned K601_GCB_F = ((BT601_GCB << (F + 1)) + D1) / (2 * D1);
   localparam longint unsigned K601_GCR_F = ((BT601_GCR << (F + 1)) + D1) / (2 * D1);
   localparam longint unsigned K601_BCB_F = ((BT601_BCB << (F + 1)) + D1) / (2 * D1);

   localparam longint unsigned K709_RCR_V =
      (((BT709_RCR * VR_CHROMA_NUM) << (F + 1)) + DV) / (2 * DV);
   localparam longint unsigned K709_GCB_V =
      (((BT709_GCB * VR_CHROMA_NUM) << (F + 1)) + DV) / (2 * DV);
   localparam longint unsigned K709_GCR_V =
      (((BT709_GCR * VR_CHROMA_NUM) << (F + 1)) + DV) / (2 * DV);
   localparam longint unsigned K709_BCB_V =
      (((BT709_BCB * VR_CHROMA_NUM) << (F + 1)) + DV) / (2 * DV);
   localparam longint unsigned K601_RCR_V =
      (((BT601_RCR * VR_CHROMA_NUM) << (F + 1)) + DV) / (2 * DV);
   localparam longint unsigned K601_GCB_V =
      (((BT601_GCB * VR_CHROMA_NUM) << (F + 1)) + DV) / (2 * DV);
   localparam longint unsigned K601_GCR_V =
      (((BT601_GCR * VR_CHROMA_NUM) << (F + 1)) + DV) / (2 * DV);
   localparam longint unsigned K601_BCB_V =
      (((BT601_BCB * VR_CHROMA_NUM) << (F + 1)) + DV) / (2 * DV);

   localparam logic signed [SW-1:0] TOP  = SW'(255) <<< F;
   localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);

   // Round half up and clamp one channel sum to a byte
   function automatic logic [PIX_W-1:0] to_byte(input logic signed [SW-1:0] sum);
      logic signed [SW-1:0] rnd;
      rnd = sum + HALF;
      if (sum <= 0) begin
         to_byte = '0;
      end else if (sum >= TOP) begin
         to_byte = '1;
      end else begin
         to_byte = rnd[F +: PIX_W];
      end
   endfunction

   // Control registers
   logic video_range_ff, video_range_in;
   logic use_bt709_ff, use_bt709_in;

   always_comb begin
      video_range_in = video_range_ff;
      use_bt709_in   = use_bt709_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_VIDEO_RANGE: video_range_in = csr_wdata[0];
            CSR_USE_BT709:   use_bt709_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         video_range_ff <= 1'b0;
         use_bt709_ff   <= 1'b0;
      end else begin
         video_range_ff <= video_range_in;
         use_bt709_ff   <= use_bt709_in;
      end
   end

   // Coefficients, user keeps static while transactions in flight; unchecked
   logic signed [CW-1:0] k_l, k_rcr, k_gcb, k_gcr, k_bcb;

   always_comb begin
      k_l = video_range_ff ? CW'(KL_V) : CW'(ONE << F);
      case ({video_range_ff, use_bt709_ff})
         2'b00: begin
            k_rcr = CW'(K601_RCR_F); k_gcb = CW'(K601_GCB_F);
            k_gcr = CW'(K601_GCR_F); k_bcb = CW'(K601_BCB_F);
         end
         2'b01: begin
            k_rcr = CW'(K709_RCR_F); k_gcb = CW'(K709_GCB_F);
            k_gcr = CW'(K709_GCR_F); k_bcb = CW'(K709_BCB_F);
         end
         2'b10: begin
            k_rcr = CW'(K601_RCR_V); k_gcb = CW'(K601_GCB_V);
            k_gcr = CW'(K601_GCR_V); k_bcb = CW'(K601_BCB_V);
         end
         default: begin
            k_rcr = CW'(K709_RCR_V); k_gcb = CW'(K709_GCB_V);
            k_gcr = CW'(K709_GCR_V); k_bcb = CW'(K709_BCB_V);
         end
      endcase
   end

   // Stage advance: a stage moves when empty or when the next one moves
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   assign en4 = !v4_ff || rsp_chan.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_chan.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // Stage 1: remove the chroma offsets, and the luma offset in video range
   logic signed [DW-1:0] y1_ff, cb1_ff, cr1_ff;
   logic signed [DW-1:0] y1_in, cb1_in, cr1_in;

   always_comb begin
      y1_in  = signed'({1'b0, req_chan.luma_sample});
      if (video_range_ff) begin
         y1_in = y1_in - DW'(LUMA_OFFSET);
      end
      cb1_in = signed'({1'b0, req_chan.cb_sample}) - DW'(CHROMA_OFFSET);
      cr1_in = signed'({1'b0, req_chan.cr_sample}) - DW'(CHROMA_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         y1_ff  <= y1_in;
         cb1_ff <= cb1_in;
         cr1_ff <= cr1_in;
      end
   end

   // Stage 2: five products
   logic signed [PW-1:0] py_ff, prcr_ff, pgcb_ff, pgcr_ff, pbcb_ff;
   logic signed [PW-1:0] py_in, prcr_in, pgcb_in, pgcr_in, pbcb_in;

   always_comb begin
      py_in   = PW'(y1_ff) * PW'(k_l);
      prcr_in = PW'(cr1_ff) * PW'(k_rcr);
      pgcb_in = PW'(cb1_ff) * PW'(k_gcb);
      pgcr_in = PW'(cr1_ff) * PW'(k_gcr);
      pbcb_in = PW'(cb1_ff) * PW'(k_bcb);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         py_ff   <= py_in;
         prcr_ff <= prcr_in;
         pgcb_ff <= pgcb_in;
         pgcr_ff <= pgcr_in;
         pbcb_ff <= pbcb_in;
      end
   end

   // Stage 3: channel sums
   logic signed [SW-1:0] r3_ff, g3_ff, b3_ff;
   logic signed [SW-1:0] r3_in, g3_in, b3_in;

   always_comb begin
      r3_in = SW'(py_ff) + SW'(prcr_ff);
      g3_in = SW'(py_ff) - SW'(pgcb_ff) - SW'(pgcr_ff);
      b3_in = SW'(py_ff) + SW'(pbcb_ff);
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         r3_ff <= r3_in;
         g3_ff <= g3_in;
         b3_ff <= b3_in;
      end
   end

   // Stage 4: clamp and round into the output register
   logic [PIX_W-1:0] red_ff, green_ff, blue_ff;
   logic [PIX_W-1:0] red_in, green_in, blue_in;

   always_comb begin
      red_in   = to_byte(r3_ff);
      green_in = to_byte(g3_ff);
      blue_in  = to_byte(b3_ff);
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_chan.valid = v4_ff;
   assign rsp_chan.red   = red_ff;
   assign rsp_chan.green = green_ff;
   assign rsp_chan.blue  = blue_ff;

   // Checks
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !v1_ff && !v4_ff, "pipeline not empty after reset")
   `ASSERT_NEXT(a_accept_s1, clock, reset, req_chan.valid && req_chan.ready, v1_ff, "accepted transaction missing in stage 1")
   `ASSERT_NEXT(a_s1_to_s2, clock, reset, v1_ff && en2, v2_ff, "transaction lost between stage 1 and stage 2")
   `ASSERT_NEXT(a_s3_to_s4, clock, reset, v3_ff && en4, v4_ff, "transaction lost between stage 3 and output")
   `ASSERT_CLK(a_ready_chain, clock, reset, (v4_ff && !rsp_chan.ready && v3_ff && v2_ff && v1_ff) |-> !req_chan.ready, "input accepted into a full stalled pipeline")

endmodule

>>> sim/ycbcr_to_rgb_converter_unit_tb.sv
// Self-checking testbench for the YCbCr to RGB converter unit.
// Depends on y2r_pkg and the channel interfaces in y2r_if.sv; drives pixels,
// predicts RGB per register setting and checks every response transaction.
module ycbcr_to_rgb_converter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import y2r_pkg::*;

   localparam int FRAC          = COEF_FRAC_BITS_DEF;
   localparam int NUM_PHASES    = 8;
   localparam int PIX_PER_PHASE = 150;
   localparam int DRAIN_CYCLES  = 8;
   localparam int WATCHDOG_MAX  = 5000;

   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic [PIX_W-1:0] cb;
      logic [PIX_W-1:0] cr;
   } yuv_pixel_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rgb_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   y2r_req_if req_chan ();
   y2r_rsp_if rsp_chan ();

   ycbcr_to_rgb_converter_unit #(
      .COEF_FRAC_BITS (FRAC)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always #4 clock = ~clock;

   // Shared testbench state
   yuv_pixel_type pending_pixels [$];
   rgb_pixel_type expected_rgb [$];
   logic          cfg_video_range = 1'b0;
   logic          cfg_bt709       = 1'b0;
   logic          no_idle         = 1'b0;
   int            mismatch_count  = 0;
   int            pixels_sent     = 0;
   int            pixels_checked  = 0;
   int            settings_run    = 0;

   // Sample values around the range and offset boundaries
   logic [PIX_W-1:0] corner_vals [13] =
      '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127, 8'd128, 8'd129,
        8'd234, 8'd235, 8'd236, 8'd254, 8'd255};

   // Coefficient in fixed point: round(num * gnum / (den * gden)), halves up
   function automatic longint fixed_coef(longint unsigned num, longint unsigned den,
                                         longint unsigned gnum, longint unsigned gden);
      longint unsigned n;
      longint unsigned d;
      n = (num * gnum) << (FRAC + 1);
      d = den * gden;
      return longint'((n + d) / (2 * d));
   endfunction

   // Clamp to 0..255, otherwise round half up
   function automatic logic [PIX_W-1:0] to_pixel(longint sum);
      longint top;
      longint rounded;
      top = longint'(255) <<< FRAC;
      if (sum <= 0) return '0;
      if (sum >= top) return 8'd255;
      rounded = (sum + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      return rounded[PIX_W-1:0];
   endfunction

   // Expected RGB for one pixel under the current register setting
   function automatic rgb_pixel_type predict_rgb(yuv_pixel_type px);
      longint          y, cb, cr, kl;
      longint          k_rcr, k_gcb, k_gcr, k_bcb;
      longint          base;
      longint unsigned gn, gd;
      rgb_pixel_type   res;
      y  = longint'(px.luma);
      cb = longint'(px.cb) - CHROMA_OFFSET;
      cr = longint'(px.cr) - CHROMA_OFFSET;
      kl = longint'(1) <<< FRAC;
      gn = 64'd1;
      gd = 64'd1;
      if (cfg_video_range) begin
         y  = y - LUMA_OFFSET;
         kl = fixed_coef(VR_LUMA_NUM, VR_LUMA_DEN, 64'd1, 64'd1);
         gn = VR_CHROMA_NUM;
         gd = VR_CHROMA_DEN;
      end
      if (cfg_bt709) begin
         k_rcr = fixed_coef(BT709_RCR, COEF_DEN, gn, gd);
         k_gcb = fixed_coef(BT709_GCB, COEF_DEN, gn, gd);
         k_gcr = fixed_coef(BT709_GCR, COEF_DEN, gn, gd);
         k_bcb = fixed_coef(BT709_BCB, COEF_DEN, gn, gd);
      end else begin
         k_rcr = fixed_coef(BT601_RCR, COEF_DEN, gn, gd);
         k_gcb = fixed_coef(BT601_GCB, COEF_DEN, gn, gd);
         k_gcr = fixed_coef(BT601_GCR, COEF_DEN, gn, gd);
         k_bcb = fixed_coef(BT601_BCB, COEF_DEN, gn, gd);
      end
      base      = kl * y;
      res.red   = to_pixel(base + k_rcr * cr);
      res.green = to_pixel(base - k_gcb * cb - k_gcr * cr);
      res.blue  = to_pixel(base + k_bcb * cb);
      return res;
   endfunction

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Mostly uniform samples, some from the boundary list
   function automatic logic [PIX_W-1:0] rand_sample();
      if ($urandom_range(0, 9) == 0) return corner_vals[$urandom_range(0, 12)];
      return PIX_W'($urandom_range(0, 255));
   endfunction

   task automatic report_channel(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Wait until the pipeline is empty, then let the latency run out
   task automatic wait_idle();
      while (pending_pixels.size() != 0 || expected_rgb.size() != 0 || req_chan.valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_registers(logic vr, logic bt);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_VIDEO_RANGE;
      csr_wdata <= vr;
      @(posedge clock);
      csr_index <= CSR_USE_BT709;
      csr_wdata <= bt;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_video_range = vr;
      cfg_bt709       = bt;
      settings_run++;
   endtask

   task automatic queue_pixel(logic [PIX_W-1:0] y, logic [PIX_W-1:0] cb,
                              logic [PIX_W-1:0] cr);
      yuv_pixel_type px;
      px.luma = y;
      px.cb   = cb;
      px.cr   = cr;
      pending_pixels = {pending_pixels, px};
   endtask

   // Request driver: presents queued pixels, predicts on each accepted transaction
   always @(posedge clock) begin : pixel_driver
      yuv_pixel_type cur_pixel;
      int            send_gap;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_rgb = {expected_rgb, predict_rgb(cur_pixel)};
            pixels_sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               cur_pixel = pending_pixels.pop_front();
               req_chan.luma_sample <= cur_pixel.luma;
               req_chan.cb_sample   <= cur_pixel.cb;
               req_chan.cr_sample   <= cur_pixel.cr;
               req_chan.valid       <= 1'b1;
               send_gap = no_idle ? 0 : pick_gap();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random back-pressure
   always @(posedge clock) begin : rgb_monitor
      rgb_pixel_type want;
      int            stall_left;
      logic          next_ready;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rgb.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual rgb %0d/%0d/%0d",
                        $time, rsp_chan.red, rsp_chan.green, rsp_chan.blue);
               mismatch_count++;
            end else begin
               want = expected_rgb.pop_front();
               report_channel("red", want.red, rsp_chan.red);
               report_channel("green", want.green, rsp_chan.green);
               report_channel("blue", want.blue, rsp_chan.blue);
               pixels_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
         rsp_chan.ready <= next_ready;
      end
   end

   // Watchdog: ends the run if no transaction moves for too long
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("%0t: timeout, %0d transactions still outstanding", $time,
                  expected_rgb.size() + pending_pixels.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Stimulus: directed corners per matrix/range setting, then random phases
   initial begin
      logic vr, bt;
      req_chan.valid       = 1'b0;
      req_chan.luma_sample = '0;
      req_chan.cb_sample   = '0;
      req_chan.cr_sample   = '0;
      rsp_chan.ready       = 1'b0;
      csr_wr_en            = 1'b0;
      csr_index            = CSR_VIDEO_RANGE;
      csr_wdata            = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         if (phase < 4) begin
            vr = phase[0];
            bt = phase[1];
         end else begin
            vr = 1'($urandom_range(0, 1));
            bt = 1'($urandom_range(0, 1));
         end
         set_registers(vr, bt);
         no_idle = (phase % 3 == 1);
         if (phase < 4) begin
            // all-zero, all-max, video black/white, chroma driven to clamp both ways
            queue_pixel(8'd0, 8'd0, 8'd0);
            queue_pixel(8'd255, 8'd255, 8'd255);
            queue_pixel(8'd16, 8'd128, 8'd128);
            queue_pixel(8'd235, 8'd128, 8'd128);
            queue_pixel(8'd128, 8'd0, 8'd255);
            queue_pixel(8'd128, 8'd255, 8'd0);
         end
         for (int i = 0; i < PIX_PER_PHASE; i++)
            queue_pixel(rand_sample(), rand_sample(), rand_sample());
      end
      wait_idle();

      $display("Ran %0d pixels through %0d register settings, %0d responses checked",
               pixels_sent, settings_run, pixels_checked);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
